### hw/rtl/efte_pkg.sv
`timescale 1ns / 1ps
package efte_pkg;

  typedef enum logic [2:0] {
    PH_ETH,
    PH_TAG1,
    PH_QINQ,
    PH_TAG2,
    PH_IP,
    PH_L4,
    PH_DONE,
    PH_ERR
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LINK      = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_OPTIONS   = 3'd3;
  localparam logic [2:0] ST_BAD_L4    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_UNDERFLOW = 3'd6;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_QINQ = 16'h88A8;

  localparam logic [7:0] TCP_PROTO = 8'd6;
  localparam logic [7:0] UDP_PROTO = 8'd17;

  localparam logic [3:0] IP_VERSION = 4'd4;
  localparam logic [3:0] IP_IHL     = 4'd5;

  // Every decision falls below offset 63, so the position counter saturates there.
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [POS_W-1:0] ETH_TYPE_LAST  = 6'd13;
  localparam logic [POS_W-1:0] TAG1_TYPE_LAST = 6'd17;
  localparam logic [POS_W-1:0] TAG2_TYPE_LAST = 6'd21;

  localparam logic [4:0] L3_NO_TAG  = 5'd14;
  localparam logic [4:0] L3_ONE_TAG = 5'd18;
  localparam logic [4:0] L3_TWO_TAG = 5'd22;

  localparam logic [5:0] IP_HDR_LEN  = 6'd20;
  localparam logic [6:0] UDP_HDR_LEN = 7'd8;

  // One finished frame, as handed from the parser to the result stage.
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  l3_start;
    logic [31:0] ip_saddr;
    logic [31:0] ip_daddr;
    logic [7:0]  protocol;
    logic [31:0] ports;
    logic [15:0] len;
    logic [3:0]  data_offset;
  } frame_rec_t;

  // Last field in the lowest bits.
  typedef struct packed {
    logic [15:0] payload_len;
    logic [6:0]  payload_offset;
    logic [5:0]  l4_offset;
    logic [15:0] l4_dport;
    logic [15:0] l4_sport;
    logic [7:0]  protocol;
    logic [31:0] ip_daddr;
    logic [31:0] ip_saddr;
    logic [2:0]  status;
  } result_t;

endpackage

### hw/rtl/efte_front.sv
`timescale 1ns / 1ps
module efte_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                frame_end,
  output logic                push,
  output efte_pkg::frame_rec_t rec
);
  import efte_pkg::*;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [15:0]       type_shift, type_shift_next;
  logic [4:0]        l3_start, l3_start_next;
  logic [31:0]       saddr, saddr_next;
  logic [31:0]       daddr, daddr_next;
  logic [7:0]        protocol, protocol_next;
  logic [31:0]       ports, ports_next;
  logic [15:0]       len, len_next;
  logic [3:0]        doff, doff_next;
  logic [2:0]        err, err_next;
  logic [POS_W-1:0]  type_last;
  logic [POS_W-1:0]  l3_pos;
  logic [POS_W-1:0]  l4_pos;
  logic [POS_W-1:0]  rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ETH;
    end else if (take) begin
      phase <= frame_end ? PH_ETH : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= frame_end ? '0 : pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      type_shift <= type_shift_next;
      l3_start   <= l3_start_next;
      saddr      <= saddr_next;
      daddr      <= daddr_next;
      protocol   <= protocol_next;
      ports      <= ports_next;
      len        <= len_next;
      doff       <= doff_next;
      err        <= err_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    pos_next        = (pos == POS_MAX) ? pos : pos + 1'b1;
    type_shift_next = type_shift;
    l3_start_next   = l3_start;
    saddr_next      = saddr;
    daddr_next      = daddr;
    protocol_next   = protocol;
    ports_next      = ports;
    len_next        = len;
    doff_next       = doff;
    err_next        = err;
    l3_pos          = {1'b0, l3_start};
    l4_pos          = l3_pos + IP_HDR_LEN;
    rel             = '0;
    type_last       = (phase == PH_ETH) ? ETH_TYPE_LAST :
                      (phase == PH_TAG2) ? TAG2_TYPE_LAST : TAG1_TYPE_LAST;
    case (phase)
      PH_ETH, PH_TAG1, PH_QINQ, PH_TAG2: begin
        if (pos == type_last - 1'b1 || pos == type_last) begin
          type_shift_next = {type_shift[7:0], data_byte};
        end
        if (pos == type_last) begin
          err_next   = ST_LINK;
          phase_next = PH_ERR;
          case (phase)
            PH_ETH: begin
              if (type_shift_next == TYPE_IPV4) begin
                l3_start_next = L3_NO_TAG;
                phase_next    = PH_IP;
              end else if (type_shift_next == TYPE_VLAN) begin
                phase_next = PH_TAG1;
              end else if (type_shift_next == TYPE_QINQ) begin
                phase_next = PH_QINQ;
              end
            end
            PH_TAG1: begin
              if (type_shift_next == TYPE_IPV4) begin
                l3_start_next = L3_ONE_TAG;
                phase_next    = PH_IP;
              end else if (type_shift_next == TYPE_VLAN) begin
                phase_next = PH_TAG2;
              end
            end
            PH_QINQ: begin
              if (type_shift_next == TYPE_VLAN) begin
                phase_next = PH_TAG2;
              end
            end
            default: begin
              if (type_shift_next == TYPE_IPV4) begin
                l3_start_next = L3_TWO_TAG;
                phase_next    = PH_IP;
              end
            end
          endcase
        end
      end
      PH_IP: begin
        if (pos >= l3_pos) begin
          rel = pos - l3_pos;
          if (rel == 6'd0) begin
            if (data_byte[7:4] != IP_VERSION) begin
              err_next   = ST_NOT_IPV4;
              phase_next = PH_ERR;
            end else if (data_byte[3:0] != IP_IHL) begin
              err_next   = ST_OPTIONS;
              phase_next = PH_ERR;
            end
          end else if (rel == 6'd2 || rel == 6'd3) begin
            len_next = {len[7:0], data_byte};
          end else if (rel == 6'd9) begin
            protocol_next = data_byte;
          end else if (rel >= 6'd12 && rel <= 6'd15) begin
            saddr_next = {saddr[23:0], data_byte};
          end else if (rel >= 6'd16 && rel <= 6'd19) begin
            daddr_next = {daddr[23:0], data_byte};
            if (rel == 6'd19) begin
              if (protocol == UDP_PROTO || protocol == TCP_PROTO) begin
                phase_next = PH_L4;
              end else begin
                err_next   = ST_BAD_L4;
                phase_next = PH_ERR;
              end
            end
          end
        end
      end
      PH_L4: begin
        if (pos >= l4_pos) begin
          rel = pos - l4_pos;
          if (rel <= 6'd3) begin
            ports_next = {ports[23:0], data_byte};
          end else if (protocol == UDP_PROTO) begin
            if (rel == 6'd4 || rel == 6'd5) begin
              len_next = {len[7:0], data_byte};
            end
            if (rel == 6'd5) begin
              phase_next = PH_DONE;
            end
          end else if (rel == 6'd12) begin
            doff_next  = data_byte[7:4];
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push = take && frame_end;

  always_comb begin
    rec.status      = (phase_next == PH_ERR)  ? err_next :
                      (phase_next == PH_DONE) ? ST_OK : ST_TRUNC;
    rec.l3_start    = l3_start_next;
    rec.ip_saddr    = saddr_next;
    rec.ip_daddr    = daddr_next;
    rec.protocol    = protocol_next;
    rec.ports       = ports_next;
    rec.len         = len_next;
    rec.data_offset = doff_next;
  end

endmodule

### hw/rtl/efte_queue.sv
`timescale 1ns / 1ps
module efte_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  efte_pkg::frame_rec_t wr_rec,
  output logic                 full,
  input  logic                 pop,
  output efte_pkg::frame_rec_t rd_rec,
  output logic                 not_empty
);
  import efte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign rd_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/efte_back.sv
`timescale 1ns / 1ps
module efte_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  efte_pkg::frame_rec_t q_rec,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output efte_pkg::result_t    m_tdata
);
  import efte_pkg::*;

  result_t     res;
  logic        is_udp;
  logic [5:0]  l4_off;
  logic [5:0]  tcp_hdr;
  logic [6:0]  hdr_sum;
  logic [16:0] diff;
  logic        under;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    is_udp  = (q_rec.protocol == UDP_PROTO);
    l4_off  = {1'b0, q_rec.l3_start} + IP_HDR_LEN;
    tcp_hdr = {q_rec.data_offset, 2'b00};
    hdr_sum = is_udp ? UDP_HDR_LEN : {1'b0, IP_HDR_LEN} + {1'b0, tcp_hdr};
    diff    = {1'b0, q_rec.len} - {10'd0, hdr_sum};
    under   = diff[16];
    res     = '0;
    if (q_rec.status != ST_OK) begin
      res.status = q_rec.status;
    end else begin
      res.status         = under ? ST_UNDERFLOW : ST_OK;
      res.ip_saddr       = q_rec.ip_saddr;
      res.ip_daddr       = q_rec.ip_daddr;
      res.protocol       = q_rec.protocol;
      res.l4_sport       = q_rec.ports[31:16];
      res.l4_dport       = q_rec.ports[15:0];
      res.l4_offset      = l4_off;
      res.payload_offset = {1'b0, l4_off} + (is_udp ? UDP_HDR_LEN : {1'b0, tcp_hdr});
      res.payload_len    = under ? 16'd0 : diff[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= res;
    end
  end

endmodule

### hw/rtl/ethernet_five_tuple_extractor_unit.sv
`timescale 1ns / 1ps
// Channel | Dir | Beat                  | Content
// s_*     | in  | one frame byte        | tdata: data_byte; tlast: frame_end
// m_*     | out | one result per frame  | tdata: result_t, 136 bits
//
// The parser takes one byte per clock while s_tready is high; a frame's result is
// registered into the output register when its record leaves the head of the frame queue.
// The frame queue holds QUEUE_DEPTH finished frames; s_tready drops only while
// it is full, so with m_tready high and QUEUE_DEPTH above one the input never stalls.
// Synchronous reset returns the parser to the Ethernet header and empties
// the queue and the output register.
module ethernet_five_tuple_extractor_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] data_byte
  input  logic          s_tlast,   // frame_end
  output logic          m_tvalid,
  input  logic          m_tready,
  // status, ip_saddr, ip_daddr, protocol, l4_sport, l4_dport,
  // l4_offset, payload_offset, payload_len (lowest bits first)
  output logic [135:0]  m_tdata
);
  import efte_pkg::*;

  logic       take;
  logic       push;
  logic       full;
  logic       pop;
  logic       not_empty;
  frame_rec_t wr_rec;
  frame_rec_t rd_rec;
  result_t    result;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;
  assign m_tdata  = result;

  efte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .frame_end (s_tlast),
    .push      (push),
    .rec       (wr_rec)
  );

  efte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_rec    (wr_rec),
    .full      (full),
    .pop       (pop),
    .rd_rec    (rd_rec),
    .not_empty (not_empty)
  );

  efte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_rec    (rd_rec),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (result)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import efte_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_BYTES   = 720;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int HOLDOFF_AFTER  = 20;
  localparam int DRAIN_CYCLES   = 16;

  localparam logic [15:0] TYPE_MPLS = 16'h8847;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'd0;  // [7:0] data_byte
  logic         s_tlast = 1'b0;  // frame_end
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;         // result_t, status in the lowest bits

  ethernet_five_tuple_extractor_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_item_t  pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  frame_buf[$];
  logic [15:0] link_types[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // Parser shadow state
  phase_t      walk_phase;
  int          frame_pos;
  logic [15:0] ethertype_window;
  int          ip_base;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  ip_proto;
  logic [31:0] port_pair;
  logic [23:0] len_reg;
  logic [2:0]  fault_code;

  task restart_frame();
    frame_pos = 0;
    walk_phase = PH_ETH;
    ethertype_window = 16'd0;
    ip_base = L3_NO_TAG;
    src_ip = 32'd0;
    dst_ip = 32'd0;
    ip_proto = 8'd0;
    port_pair = 32'd0;
    len_reg = 24'd0;
    fault_code = ST_OK;
  endtask

  task mark_fault(input logic [2:0] code);
    fault_code = code;
    walk_phase = PH_ERR;
  endtask

  task absorb_byte(input logic [7:0] b);
    int type_last;
    int rel;
    case (walk_phase)
      PH_ETH, PH_TAG1, PH_QINQ, PH_TAG2: begin
        type_last = (walk_phase == PH_ETH) ? ETH_TYPE_LAST :
                    (walk_phase == PH_TAG2) ? TAG2_TYPE_LAST : TAG1_TYPE_LAST;
        if (frame_pos + 1 >= type_last && frame_pos <= type_last) begin
          ethertype_window = {ethertype_window[7:0], b};
          if (frame_pos == type_last) begin
            case (walk_phase)
              PH_ETH: begin
                if (ethertype_window == TYPE_IPV4) begin
                  ip_base = L3_NO_TAG;
                  walk_phase = PH_IP;
                end else if (ethertype_window == TYPE_VLAN) walk_phase = PH_TAG1;
                else if (ethertype_window == TYPE_QINQ) walk_phase = PH_QINQ;
                else mark_fault(ST_LINK);
              end
              PH_TAG1: begin
                if (ethertype_window == TYPE_IPV4) begin
                  ip_base = L3_ONE_TAG;
                  walk_phase = PH_IP;
                end else if (ethertype_window == TYPE_VLAN) walk_phase = PH_TAG2;
                else mark_fault(ST_LINK);
              end
              PH_QINQ: begin
                if (ethertype_window == TYPE_VLAN) walk_phase = PH_TAG2;
                else mark_fault(ST_LINK);
              end
              default: begin
                if (ethertype_window == TYPE_IPV4) begin
                  ip_base = L3_TWO_TAG;
                  walk_phase = PH_IP;
                end else mark_fault(ST_LINK);
              end
            endcase
          end
        end
      end
      PH_IP: begin
        if (frame_pos >= ip_base) begin
          rel = frame_pos - ip_base;
          if (rel == 0) begin
            if (b[7:4] != IP_VERSION) mark_fault(ST_NOT_IPV4);
            else if (b[3:0] != IP_IHL) mark_fault(ST_OPTIONS);
          end else if (rel == 2 || rel == 3) begin
            len_reg[15:0] = {len_reg[7:0], b};
          end else if (rel == 9) begin
            ip_proto = b;
          end else if (rel >= 12 && rel <= 15) begin
            src_ip = {src_ip[23:0], b};
          end else if (rel >= 16 && rel <= 19) begin
            dst_ip = {dst_ip[23:0], b};
            if (rel == 19) begin
              if (ip_proto == UDP_PROTO || ip_proto == TCP_PROTO) walk_phase = PH_L4;
              else mark_fault(ST_BAD_L4);
            end
          end
        end
      end
      PH_L4: begin
        if (frame_pos >= ip_base + IP_HDR_LEN) begin
          rel = frame_pos - (ip_base + IP_HDR_LEN);
          if (rel <= 3) begin
            port_pair = {port_pair[23:0], b};
          end else if (ip_proto == UDP_PROTO) begin
            if (rel == 4 || rel == 5) len_reg[15:0] = {len_reg[7:0], b};
            if (rel == 5) walk_phase = PH_DONE;
          end else if (rel == 12) begin
            len_reg[23:16] = b;
            walk_phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task close_frame();
    result_t r;
    int l4_at;
    int poff;
    int plen;
    int hdr_len;
    r = '0;
    if (walk_phase == PH_ERR) begin
      r.status = fault_code;
    end else if (walk_phase != PH_DONE) begin
      r.status = ST_TRUNC;
    end else begin
      l4_at = ip_base + IP_HDR_LEN;
      if (ip_proto == UDP_PROTO) begin
        poff = l4_at + UDP_HDR_LEN;
        plen = int'(len_reg[15:0]) - int'(UDP_HDR_LEN);
      end else begin
        hdr_len = int'(len_reg[23:20]) * 4;
        poff = l4_at + hdr_len;
        plen = int'(len_reg[15:0]) - int'(IP_HDR_LEN) - hdr_len;
      end
      r.ip_saddr = src_ip;
      r.ip_daddr = dst_ip;
      r.protocol = ip_proto;
      r.l4_sport = port_pair[31:16];
      r.l4_dport = port_pair[15:0];
      r.l4_offset = 6'(l4_at);
      r.payload_offset = 7'(poff);
      if (plen < 0) begin
        r.status = ST_UNDERFLOW;
        r.payload_len = 16'd0;
      end else begin
        r.status = ST_OK;
        r.payload_len = 16'(plen);
      end
    end
    expected_results.push_back(r);
  endtask

  task take_frame_byte(input logic [7:0] b, input logic last);
    absorb_byte(b);
    if (frame_pos < 65535) frame_pos++;
    if (last) begin
      close_frame();
      restart_frame();
    end
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  // Cut or pad the frame to send_len bytes (whole frame when zero) and queue it.
  task queue_frame(input int send_len);
    byte_item_t item;
    int n;
    n = (send_len > 0) ? send_len : frame_buf.size();
    while (frame_buf.size() < n) frame_buf.push_back(any_byte());
    for (int i = 0; i < n; i++) begin
      item.data = frame_buf[i];
      item.last = (i == n - 1);
      pending_bytes.push_back(item);
    end
  endtask

  task build_frame(input logic [7:0] vihl, input logic [7:0] proto,
                   input logic [15:0] total_len, input logic [31:0] src,
                   input logic [31:0] dst, input logic [15:0] sport,
                   input logic [15:0] dport, input logic [15:0] udp_len,
                   input logic [7:0] tcp_off, input int payload, input int send_len);
    frame_buf.delete();
    repeat (12) frame_buf.push_back(any_byte());
    foreach (link_types[i]) begin
      if (i > 0) repeat (2) frame_buf.push_back(any_byte());
      frame_buf.push_back(link_types[i][15:8]);
      frame_buf.push_back(link_types[i][7:0]);
    end
    frame_buf.push_back(vihl);
    frame_buf.push_back(any_byte());
    frame_buf.push_back(total_len[15:8]);
    frame_buf.push_back(total_len[7:0]);
    repeat (5) frame_buf.push_back(any_byte());
    frame_buf.push_back(proto);
    repeat (2) frame_buf.push_back(any_byte());
    for (int i = 3; i >= 0; i--) frame_buf.push_back(src[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(dst[8*i +: 8]);
    frame_buf.push_back(sport[15:8]);
    frame_buf.push_back(sport[7:0]);
    frame_buf.push_back(dport[15:8]);
    frame_buf.push_back(dport[7:0]);
    if (proto == UDP_PROTO) begin
      frame_buf.push_back(udp_len[15:8]);
      frame_buf.push_back(udp_len[7:0]);
      repeat (2) frame_buf.push_back(any_byte());
    end else if (proto == TCP_PROTO) begin
      repeat (8) frame_buf.push_back(any_byte());
      frame_buf.push_back(tcp_off);
      repeat (7) frame_buf.push_back(any_byte());
    end else begin
      repeat (4) frame_buf.push_back(any_byte());
    end
    repeat (payload) frame_buf.push_back(any_byte());
    queue_frame(send_len);
  endtask

  task queue_random_frame();
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [15:0] udp_len;
    int          payload;
    int          send_len;
    int          pick;
    // Line noise: a frame of arbitrary bytes
    if ($urandom_range(0, 19) == 0) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 70)) frame_buf.push_back(any_byte());
      queue_frame(0);
      return;
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: link_types = {TYPE_IPV4};
      3, 4:    link_types = {TYPE_VLAN, TYPE_IPV4};
      5, 6:    link_types = {TYPE_QINQ, TYPE_VLAN, TYPE_IPV4};
      7:       link_types = {TYPE_VLAN, TYPE_VLAN, TYPE_IPV4};
      8: begin
        case ($urandom_range(0, 6))
          0: link_types = {TYPE_MPLS};
          1: link_types = {TYPE_IPV6};
          2: link_types = {TYPE_ARP};
          3: link_types = {TYPE_VLAN, TYPE_ARP};
          4: link_types = {TYPE_QINQ, TYPE_IPV4};
          5: link_types = {TYPE_VLAN, TYPE_VLAN, TYPE_VLAN};
          default: link_types = {TYPE_QINQ, TYPE_VLAN, TYPE_QINQ};
        endcase
      end
      default: link_types = {16'($urandom), 16'($urandom), 16'($urandom)};
    endcase
    vihl = ($urandom_range(0, 9) == 0) ? any_byte() : {IP_VERSION, IP_IHL};
    pick = $urandom_range(0, 9);
    proto = (pick < 4) ? UDP_PROTO : (pick < 8) ? TCP_PROTO : any_byte();
    total_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 120)) : 16'($urandom);
    udp_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    payload = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
    send_len = 0;
    if ($urandom_range(0, 6) == 0)
      send_len = $urandom_range(1, 42 + 4 * link_types.size());
    build_frame(vihl, proto, total_len, $urandom, $urandom, 16'($urandom), 16'($urandom),
                udp_len, any_byte(), payload, send_len);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : byte_driver
    byte_item_t next_item;
    logic       next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) take_frame_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          s_tdata <= next_item.data;
          s_tlast <= next_item.last;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_tvalid <= next_valid;
      end
    end
  end

  task compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected, status %0d", got.status);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("ip_saddr", want.ip_saddr, got.ip_saddr);
      compare_field("ip_daddr", want.ip_daddr, got.ip_daddr);
      compare_field("protocol", want.protocol, got.protocol);
      compare_field("l4_sport", want.l4_sport, got.l4_sport);
      compare_field("l4_dport", want.l4_dport, got.l4_dport);
      compare_field("l4_offset", want.l4_offset, got.l4_offset);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("payload_len", want.payload_len, got.payload_len);
    end
  endtask

  // Receiver: its own stall pattern, plus one long hold-off to fill the frame queue
  int   results_checked = 0;
  int   holdoff_left = 0;
  logic holdoff_used = 1'b0;
  int   ready_run = 0;
  logic stalled = 1'b0;

  always @(posedge clk) begin : result_monitor
    logic next_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        results_checked++;
      end
      if (!holdoff_used && results_checked >= HOLDOFF_AFTER) begin
        holdoff_used = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        next_ready = 1'b0;
      end else begin
        if (ready_run == 0) begin
          stalled = ($urandom_range(0, 3) == 0);
          if (stalled) ready_run = $urandom_range(1, 6);
          else ready_run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
        end
        ready_run--;
        next_ready = !stalled;
      end
      m_tready <= next_ready;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int directed_bytes;
    restart_frame();

    // Field extremes, all link shapes, payload length at and below zero
    link_types = {TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                16'hFFFF, 16'h0, 16'hFFFF, 8'h00, 0, 0);
    link_types = {TYPE_VLAN, TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'h0, 32'h0, 32'hFFFF_FFFF,
                16'h0, 16'hFFFF, 16'd8, 8'hFF, 2, 0);
    link_types = {TYPE_VLAN, TYPE_VLAN, TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd40, $urandom, $urandom,
                16'h1234, 16'h5678, 16'd0, 8'h00, 0, 0);
    link_types = {TYPE_QINQ, TYPE_VLAN, TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd80, $urandom, $urandom,
                16'hA5A5, 16'h5A5A, 16'd0, 8'hF0, 60, 0);
    // Data offset below five words is taken as is; a total length short of the headers underflows
    link_types = {TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd100, $urandom, $urandom,
                16'($urandom), 16'($urandom), 16'd0, 8'h0F, 3, 0);
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd30, $urandom, $urandom,
                16'($urandom), 16'($urandom), 16'd0, 8'h50, 0, 0);

    // Link types that are not accepted
    link_types = {TYPE_MPLS};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);
    link_types = {TYPE_IPV6};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);
    link_types = {TYPE_VLAN, TYPE_ARP};
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd0, 8'h50, 0, 0);
    link_types = {TYPE_QINQ, TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);
    link_types = {TYPE_VLAN, TYPE_VLAN, TYPE_VLAN};
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);

    // Bad version, options, version and length both bad, unknown transport
    link_types = {TYPE_IPV4};
    build_frame(8'h65, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);
    build_frame(8'h46, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 0);
    build_frame(8'h00, TCP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd0, 8'h50, 0, 0);
    build_frame({IP_VERSION, IP_IHL}, 8'd1, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd0, 8'h00, 0, 0);

    // Short frames: one byte, and one byte short of the last needed field
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 1);
    build_frame({IP_VERSION, IP_IHL}, UDP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd20, 8'h00, 0, 39);
    link_types = {TYPE_VLAN, TYPE_IPV4};
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd60, $urandom, $urandom,
                16'd1, 16'd2, 16'd0, 8'h50, 0, 50);
    // Long frame runs the position counter past its top
    build_frame({IP_VERSION, IP_IHL}, TCP_PROTO, 16'd1500, $urandom, $urandom,
                16'($urandom), 16'($urandom), 16'd0, 8'h80, 90, 0);

    directed_bytes = pending_bytes.size();
    while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) queue_random_frame();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
hw/rtl/efte_pkg.sv
hw/rtl/efte_front.sv
hw/rtl/efte_queue.sv
hw/rtl/efte_back.sv
hw/rtl/ethernet_five_tuple_extractor_unit.sv
verif/tb_top.sv
